[src/mmcs_pkg.sv]
package mmcs_pkg;

  localparam int PIX_W   = 16;
  localparam int SCALE_W = 32;
  localparam int PROD_W  = PIX_W + SCALE_W;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam int DIV_CW  = $clog2(SCALE_W);

  localparam logic [SCALE_W-1:0] SCALE_NUM = 32'hFFFF_0000;
  localparam logic [PIX_W-1:0]   PIX_MAX   = '1;

  localparam logic MODE_MEASURE = 1'b0;
  localparam logic MODE_SCALE   = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [PIX_W-1:0] pixel;
    logic [PIX_W-1:0] min_v;
    logic [PIX_W-1:0] max_v;
    logic             last;
  } item_t;

endpackage

[src/mmcs_in_if.sv]
interface mmcs_in_if;
  import mmcs_pkg::*;

  logic             valid;
  logic             ready;
  logic             mode;
  logic [PIX_W-1:0] pixel_value;
  logic             last_of_frame;

  modport source (output valid, mode, pixel_value, last_of_frame, input ready);
  modport sink   (input valid, mode, pixel_value, last_of_frame, output ready);

endinterface

[src/mmcs_out_if.sv]
interface mmcs_out_if;
  import mmcs_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] stretched_pixel;
  logic [PIX_W-1:0] min_so_far;
  logic [PIX_W-1:0] max_so_far;
  logic             flat_frame;
  logic             clipped;

  modport source (output valid, stretched_pixel, min_so_far, max_so_far, flat_frame, clipped,
                  input ready);
  modport sink   (input valid, stretched_pixel, min_so_far, max_so_far, flat_frame, clipped,
                  output ready);

endinterface

[src/mmcs_front.sv]
module mmcs_front (
  input  logic           clk,
  input  logic           rst_n,
  mmcs_in_if.sink        in_word,
  output logic           push_valid,
  input  logic           push_ready,
  output mmcs_pkg::item_t push_item
);
  import mmcs_pkg::*;

  logic [PIX_W-1:0] run_min_r, run_min_nxt;
  logic [PIX_W-1:0] run_max_r, run_max_nxt;
  logic [PIX_W-1:0] new_min;
  logic [PIX_W-1:0] new_max;
  logic             accept;

  assign in_word.ready = push_ready;
  assign push_valid    = in_word.valid;
  assign accept        = in_word.valid & push_ready;

  assign new_min = (in_word.pixel_value < run_min_r) ? in_word.pixel_value : run_min_r;
  assign new_max = (in_word.pixel_value > run_max_r) ? in_word.pixel_value : run_max_r;

  always_comb begin
    push_item.mode  = in_word.mode;
    push_item.pixel = in_word.pixel_value;
    push_item.last  = in_word.last_of_frame;
    if (in_word.mode == MODE_MEASURE) begin
      push_item.min_v = new_min;
      push_item.max_v = new_max;
    end else begin
      push_item.min_v = run_min_r;
      push_item.max_v = run_max_r;
    end
  end

  // extrema restart after the last pixel of a measure pass
  always_comb begin
    run_min_nxt = run_min_r;
    run_max_nxt = run_max_r;
    if (accept && in_word.mode == MODE_MEASURE) begin
      if (in_word.last_of_frame) begin
        run_min_nxt = PIX_MAX;
        run_max_nxt = '0;
      end else begin
        run_min_nxt = new_min;
        run_max_nxt = new_max;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_min_r <= PIX_MAX;
      run_max_r <= '0;
    end else begin
      run_min_r <= run_min_nxt;
      run_max_r <= run_max_nxt;
    end
  end

endmodule

[src/mmcs_fifo.sv]
module mmcs_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  mmcs_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output mmcs_pkg::item_t pop_item
);
  import mmcs_pkg::*;

  item_t           mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_CW-1:0] count_r;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count_r != Q_CW'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + Q_CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - Q_CW'(1);
      end
    end
  end

endmodule

[src/mmcs_back.sv]
module mmcs_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  mmcs_pkg::item_t pop_item,
  mmcs_out_if.source      out_word
);
  import mmcs_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]         state_r;
  item_t              cur_r;
  logic               below_r;
  logic [PROD_W-1:0]  prod_r;
  logic [PIX_W-1:0]   lmin_r;
  logic [SCALE_W-1:0] scale_r;
  logic               flat_r;
  logic [PIX_W-1:0]   div_d_r;
  logic [PIX_W-1:0]   rem_r;
  logic [SCALE_W-1:0] quo_r;
  logic [DIV_CW-1:0]  cnt_r;

  logic               out_valid_r;
  logic [PIX_W-1:0]   out_pix_r;
  logic [PIX_W-1:0]   out_min_r;
  logic [PIX_W-1:0]   out_max_r;
  logic               out_flat_r;
  logic               out_clip_r;

  logic               take;
  logic               below;
  logic [PIX_W-1:0]   diff;
  logic [PIX_W-1:0]   range_v;
  logic [PROD_W-1:0]  prod_nxt;
  logic [PIX_W:0]     trial;
  logic               qbit;
  logic [PIX_W:0]     trial_sub;
  logic [SCALE_W-1:0] quo_nxt;
  logic               out_free;
  logic [PIX_W-1:0]   res_pix;
  logic               res_clip;

  assign pop_ready = (state_r == S_IDLE);
  assign take      = pop_valid & pop_ready;

  assign below    = (pop_item.pixel < lmin_r);
  assign diff     = below ? '0 : (pop_item.pixel - lmin_r);
  assign prod_nxt = diff * scale_r;
  assign range_v  = pop_item.max_v - pop_item.min_v;

  // restoring division, one quotient bit a cycle
  assign trial     = {rem_r, quo_r[SCALE_W-1]};
  assign qbit      = (trial >= {1'b0, div_d_r});
  assign trial_sub = trial - {1'b0, div_d_r};
  assign quo_nxt   = {quo_r[SCALE_W-2:0], qbit};

  assign out_free = !out_valid_r || out_word.ready;

  always_comb begin
    res_pix  = '0;
    res_clip = 1'b0;
    if (cur_r.mode == MODE_SCALE) begin
      if (below_r) begin
        res_clip = 1'b1;
      end else if (!flat_r) begin
        if (|prod_r[PROD_W-1:SCALE_W]) begin
          res_pix  = PIX_MAX;
          res_clip = 1'b1;
        end else begin
          res_pix = prod_r[SCALE_W-1:PIX_W];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_r   <= pop_item;
      below_r <= below;
      prod_r  <= prod_nxt;
    end
    if (take && pop_item.mode == MODE_MEASURE && pop_item.last) begin
      div_d_r <= range_v;
      rem_r   <= '0;
      quo_r   <= SCALE_NUM;
    end else if (state_r == S_DIV) begin
      rem_r <= qbit ? trial_sub[PIX_W-1:0] : trial[PIX_W-1:0];
      quo_r <= quo_nxt;
    end
    if (state_r == S_EMIT && out_free) begin
      out_pix_r  <= res_pix;
      out_min_r  <= cur_r.min_v;
      out_max_r  <= cur_r.max_v;
      out_flat_r <= flat_r;
      out_clip_r <= res_clip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      lmin_r      <= '0;
      scale_r     <= '0;
      flat_r      <= 1'b1;
    end else begin
      if (state_r == S_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_word.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (take) begin
            if (pop_item.mode == MODE_MEASURE && pop_item.last) begin
              lmin_r <= pop_item.min_v;
              if (range_v == '0) begin
                scale_r <= '0;
                flat_r  <= 1'b1;
                state_r <= S_EMIT;
              end else begin
                cnt_r   <= '0;
                state_r <= S_DIV;
              end
            end else begin
              state_r <= S_EMIT;
            end
          end
        end
        S_DIV: begin
          cnt_r <= cnt_r + DIV_CW'(1);
          if (cnt_r == DIV_CW'(SCALE_W - 1)) begin
            scale_r <= quo_nxt;
            flat_r  <= 1'b0;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_word.valid           = out_valid_r;
  assign out_word.stretched_pixel = out_pix_r;
  assign out_word.min_so_far      = out_min_r;
  assign out_word.max_so_far      = out_max_r;
  assign out_word.flat_frame      = out_flat_r;
  assign out_word.clipped         = out_clip_r;

endmodule

[src/min_max_contrast_stretch.sv]
// channel   dir  handshake       payload
// in_word   in   valid / ready   mode, pixel_value, last_of_frame
// out_word  out  valid / ready   stretched_pixel, min_so_far, max_so_far, flat_frame, clipped
//
// the front takes one word a cycle while the four-entry queue has room
// the back handles each word by a pop with multiply, then an output register load, and pops no new word until then
// the last word of a measure pass also runs the bit-serial scale division, unless its range is zero
// reset: extrema 65535 and 0, latched minimum 0, scale 0, flat flag set
// a stalled output holds the back, and the queue then fills before in_word.ready drops
module min_max_contrast_stretch (
  input  logic       clk,
  input  logic       rst_n,
  mmcs_in_if.sink    in_word,
  mmcs_out_if.source out_word
);
  import mmcs_pkg::*;

  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_item;

  mmcs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_word),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  mmcs_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  mmcs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_word  (out_word)
  );

endmodule
